>>> design/iida_pkg.sv
// Package for the indexed insert/delete array: request and result payload
// types, operation codes and status codes. No dependencies.
package iida_pkg;

    // Field widths of the request and result channels.
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 7;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd4;

    // Status codes returned with every result.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // One request on the input channel.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } iida_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [STAT_W-1:0]        status;
        logic [FILL_W-1:0]        fill_count;
    } iida_res_t;

endpackage

>>> design/iida_word_ram.sv
// Word store of the indexed insert/delete array: a simple dual-port memory
// with one write port and one registered read port. No dependencies.
module iida_word_ram #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]     rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write port and registered read port; a read that shares its entry with
    // a write in the same cycle is never used in this design.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/indexed_insert_delete_array.sv
// Indexed insert/delete array: an ordered store of up to DEPTH words held in
// one synchronous memory with a fill count. Append, write, an unused selector
// and any request that fails its index or full check go from idle straight to
// the response state. Read and remove of the last word pass through the read
// wait state, and insert at the end through the final state. An insert that
// moves words passes through the shift and final states, a remove that moves
// words through the read wait, shift and final states; the words above the
// index are moved one entry per cycle through the single read and single
// write port of the memory. One request is in flight at a time; a finished
// result waits in the output register while the next request is taken, and
// a request whose result finds that register still held waits in the response
// state while the result side holds off. Depends on iida_pkg and iida_word_ram.
module indexed_insert_delete_array #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iida_pkg::iida_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output iida_pkg::iida_res_t m_res
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > iida_pkg::POS_W) ? CNT_W : iida_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SHIFT,
        ST_FINAL,
        ST_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [AW-1:0]                 src_reg, src_next;
    logic [AW-1:0]                 last_reg, last_next;
    logic [AW-1:0]                 dst_reg, dst_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic                          up_reg, up_next;
    logic                          more_reg, more_next;
    logic                          pend_reg, pend_next;
    logic                          ins_reg, ins_next;
    logic [WORD_BITS-1:0]          word_reg, word_next;
    logic [iida_pkg::WORD_W-1:0]   res_word_reg, res_word_next;
    logic [iida_pkg::STAT_W-1:0]   status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    iida_pkg::iida_res_t           m_res_reg, m_res_next;

    logic                          mem_we;
    logic [AW-1:0]                 mem_wa;
    logic [WORD_BITS-1:0]          mem_wd;
    logic [AW-1:0]                 mem_ra;
    logic [WORD_BITS-1:0]          mem_rd;

    logic [CMP_W-1:0]              pos_c;
    logic [CMP_W-1:0]              n_c;
    logic                          full;
    logic [WORD_BITS-1:0]          w_in;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // Request fields brought to the widths of the count and the store.
    assign pos_c = CMP_W'(s_req.position);
    assign n_c   = CMP_W'(cnt_reg);
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign w_in  = WORD_BITS'($unsigned(s_req.word_in));

    iida_word_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    // Sequencer: decode and check in idle, then read, shift and write back.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        last_next     = last_reg;
        dst_next      = dst_reg;
        pos_next      = pos_reg;
        up_next       = up_reg;
        more_next     = more_reg;
        pend_next     = pend_reg;
        ins_next      = ins_reg;
        word_next     = word_reg;
        res_word_next = res_word_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_res_next    = m_res_reg;
        mem_we        = 1'b0;
        mem_wa        = dst_reg;
        mem_wd        = mem_rd;
        mem_ra        = src_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next      = AW'(s_req.position);
                    word_next     = w_in;
                    res_word_next = '0;
                    status_next   = iida_pkg::STATUS_OK;
                    ins_next      = 1'b0;
                    more_next     = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = ST_RESP;
                    unique case (s_req.func)
                        iida_pkg::FUNC_APPEND: begin
                            if (full) begin
                                status_next = iida_pkg::STATUS_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                mem_wa   = AW'(cnt_reg);
                                mem_wd   = w_in;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        iida_pkg::FUNC_INSERT: begin
                            if (pos_c > n_c) begin
                                status_next = iida_pkg::STATUS_RANGE;
                            end else if (full) begin
                                status_next = iida_pkg::STATUS_FULL;
                            end else begin
                                cnt_next = cnt_reg + 1'b1;
                                ins_next = 1'b1;
                                if (pos_c < n_c) begin
                                    // Move words from the top down to the index.
                                    src_next   = AW'(cnt_reg - 1'b1);
                                    last_next  = AW'(s_req.position);
                                    up_next    = 1'b1;
                                    more_next  = 1'b1;
                                    state_next = ST_SHIFT;
                                end else begin
                                    state_next = ST_FINAL;
                                end
                            end
                        end
                        iida_pkg::FUNC_REMOVE: begin
                            if (pos_c >= n_c) begin
                                status_next = iida_pkg::STATUS_RANGE;
                            end else begin
                                mem_ra     = AW'(s_req.position);
                                cnt_next   = cnt_reg - 1'b1;
                                src_next   = AW'(s_req.position) + 1'b1;
                                last_next  = AW'(cnt_reg - 1'b1);
                                up_next    = 1'b0;
                                more_next  = (pos_c + 1'b1) != n_c;
                                state_next = ST_RD_WAIT;
                            end
                        end
                        iida_pkg::FUNC_READ: begin
                            if (pos_c >= n_c) begin
                                status_next = iida_pkg::STATUS_RANGE;
                            end else begin
                                mem_ra     = AW'(s_req.position);
                                state_next = ST_RD_WAIT;
                            end
                        end
                        iida_pkg::FUNC_WRITE: begin
                            if (pos_c >= n_c) begin
                                status_next = iida_pkg::STATUS_RANGE;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = AW'(s_req.position);
                                mem_wd = w_in;
                            end
                        end
                        default: begin
                            status_next = iida_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                // The word at the index arrives from the memory.
                res_word_next = iida_pkg::WORD_W'(mem_rd);
                state_next    = more_reg ? ST_SHIFT : ST_RESP;
            end
            ST_SHIFT: begin
                // Write back the word read last cycle, one entry over.
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = dst_reg;
                    mem_wd = mem_rd;
                end
                if (more_reg) begin
                    mem_ra    = src_reg;
                    pend_next = 1'b1;
                    dst_next  = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next  = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    more_next = (src_reg != last_reg);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // An insert drops its word into the opened slot.
                if (ins_reg) begin
                    mem_we = 1'b1;
                    mem_wa = pos_reg;
                    mem_wd = word_reg;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_res_next.word_out   = res_word_reg;
                    m_res_next.status     = status_reg;
                    m_res_next.fill_count = iida_pkg::FILL_W'(cnt_reg);
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, count and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            more_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            ins_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            more_reg    <= more_next;
            pend_reg    <= pend_next;
            ins_reg     <= ins_next;
            m_valid_reg <= m_valid_next;
        end
        src_reg      <= src_next;
        last_reg     <= last_next;
        dst_reg      <= dst_next;
        pos_reg      <= pos_next;
        up_reg       <= up_next;
        word_reg     <= word_next;
        res_word_reg <= res_word_next;
        status_reg   <= status_next;
        m_res_reg    <= m_res_next;
    end

    // The fill count never passes the store depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // The fill count changes only when a request is accepted.
    a_cnt_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> $stable(cnt_reg))
        else $error("fill count changed without a request");

    // The memory is written in idle only for an accepted request.
    a_we_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_IDLE) |-> s_valid)
        else $error("memory write in idle without a request");

    // A result that can be loaded shows up on the next cycle.
    a_resp_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!m_valid_reg || m_ready)) |=>
            (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not delivered from response state");

    // A shift in progress always has a pending write or a read to issue.
    a_shift_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (pend_reg || more_reg))
        else $error("shift state with nothing to do");

endmodule

>>> sim/iida_checker.sv
`timescale 1ns / 100ps
// Checker for the indexed insert/delete array: watches both channels, predicts each
// result from the accepted requests and compares it field by field.
// Depends on iida_pkg.
module iida_checker
    import iida_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  iida_req_t s_req,
    input  logic      m_valid,
    input  logic      m_ready,
    input  iida_res_t m_res,
    output int        mismatches,
    output int        outstanding
);

    // Shadow copy of the ordered store and its fill count.
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_fill;
    iida_res_t                expected_results [$];

    // Apply one request to the shadow store and work out the result it yields.
    task automatic predict_result(input iida_req_t req, output iida_res_t res);
        int pos;
        int i;
        pos = int'(req.position);
        res = '0;
        res.status = STATUS_OK;
        case (req.func)
            FUNC_APPEND: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_words[shadow_fill] = req.word_in;
                    shadow_fill++;
                end
            end
            FUNC_INSERT: begin
                // The index check wins over the full check.
                if (pos > shadow_fill) begin
                    res.status = STATUS_RANGE;
                end else if (shadow_fill >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (i = shadow_fill; i > pos; i--) begin
                        shadow_words[i] = shadow_words[i-1];
                    end
                    shadow_words[pos] = req.word_in;
                    shadow_fill++;
                end
            end
            FUNC_REMOVE: begin
                if (pos >= shadow_fill) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.word_out = shadow_words[pos];
                    for (i = pos; i + 1 < shadow_fill; i++) begin
                        shadow_words[i] = shadow_words[i+1];
                    end
                    shadow_fill--;
                    shadow_words[shadow_fill] = '0;
                end
            end
            FUNC_READ: begin
                if (pos >= shadow_fill) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.word_out = shadow_words[pos];
                end
            end
            FUNC_WRITE: begin
                if (pos >= shadow_fill) begin
                    res.status = STATUS_RANGE;
                end else begin
                    shadow_words[pos] = req.word_in;
                end
            end
            default: begin
                // Unused selectors leave everything as it is.
            end
        endcase
        res.fill_count = shadow_fill[FILL_W-1:0];
    endtask

    // Results are retired before new requests are predicted, so an unexpected
    // result can never be matched against a request taken at the same edge.
    always @(posedge aclk) begin : monitor
        iida_res_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            foreach (shadow_words[i]) shadow_words[i] = '0;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: word_out %0d status %0d fill_count %0d",
                           m_res.word_out, m_res.status, m_res.fill_count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_res.word_out !== want.word_out) begin
                        $error("word_out: expected %0d, got %0d", want.word_out, m_res.word_out);
                        mismatches++;
                    end
                    if (m_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_res.status);
                        mismatches++;
                    end
                    if (m_res.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, m_res.fill_count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_result(s_req, want);
                expected_results.push_back(want);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the indexed insert/delete array: clock, reset, request and
// result traffic and the verdict. Depends on iida_pkg, the array and iida_checker.
module tb;
    import iida_pkg::*;

    localparam int DEPTH          = 64;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int POS_MAX        = 127;

    // Selectors the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    // Traffic mixes for the random part.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;
    localparam int MODE_FILL   = 3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    iida_req_t s_req;
    logic      m_valid;
    logic      m_ready;
    iida_res_t m_res;
    int        mismatches;
    int        outstanding;

    int fill_mirror;
    int sent_count;
    bit calm;
    int idle_cycles;

    indexed_insert_delete_array #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_W)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_res  (m_res)
    );

    iida_checker #(
        .DEPTH(DEPTH)
    ) u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one request, idling first at random, and wait for it to be taken.
    // The fill count is tracked to steer indexes toward the valid range and to tell when the store is full.
    task automatic send_request(input logic [FUNC_W-1:0] func, input int pos,
                                input logic [WORD_W-1:0] word);
        iida_req_t req;
        req.func     = func;
        req.position = pos[POS_W-1:0];
        req.word_in  = word;
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        case (func)
            FUNC_APPEND: if (fill_mirror < DEPTH) fill_mirror++;
            FUNC_INSERT: if (pos <= fill_mirror && fill_mirror < DEPTH) fill_mirror++;
            FUNC_REMOVE: if (pos < fill_mirror) fill_mirror--;
            default: ;
        endcase
    endtask

    // Words lean on the signed extremes, zero and all ones.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly valid indexes, some on the first invalid one, a few anywhere.
    function automatic int pick_position(input logic [FUNC_W-1:0] func);
        int top_valid;
        int roll;
        roll      = $urandom_range(0, 99);
        top_valid = (func == FUNC_INSERT) ? fill_mirror : fill_mirror - 1;
        if (roll < 8) return $urandom_range(0, POS_MAX);
        if (roll < 16 || top_valid < 0) return top_valid + 1;
        return $urandom_range(0, top_valid);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        case (mode)
            MODE_GROW: begin
                if (roll < 35) return FUNC_APPEND;
                if (roll < 65) return FUNC_INSERT;
                if (roll < 75) return FUNC_REMOVE;
                if (roll < 88) return FUNC_READ;
                return FUNC_WRITE;
            end
            MODE_SHRINK: begin
                if (roll < 10) return FUNC_APPEND;
                if (roll < 25) return FUNC_INSERT;
                if (roll < 65) return FUNC_REMOVE;
                if (roll < 85) return FUNC_READ;
                return FUNC_WRITE;
            end
            default: begin
                if (roll < 23) return FUNC_APPEND;
                if (roll < 43) return FUNC_INSERT;
                if (roll < 68) return FUNC_REMOVE;
                if (roll < 85) return FUNC_READ;
                return FUNC_WRITE;
            end
        endcase
    endfunction

    // Result side: random stalls, one long hold-off once traffic is flowing.
    initial begin : result_side
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    // Give up when no request or result moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_insert_delete_array: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : request_side
        int                item_count;
        int                batch;
        int                mode;
        logic [FUNC_W-1:0] func;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req       = '0;
        calm        = 1'b0;
        sent_count  = 0;
        fill_mirror = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, signed extremes, inserts at the front, middle
        // and end, boundary indexes, removes of first, middle and last word,
        // and the ignored selectors.
        send_request(FUNC_READ,   0, 32'h1234_5678);
        send_request(FUNC_REMOVE, 0, '0);
        send_request(FUNC_WRITE,  0, 32'h0bad_f00d);
        send_request(FUNC_INSERT, 1, 32'h1111_1111);
        send_request(FUNC_INSERT, 0, 32'h7fff_ffff);
        send_request(FUNC_APPEND, 0, 32'h8000_0000);
        send_request(FUNC_APPEND, 0, '1);
        send_request(FUNC_INSERT, 1, '0);
        send_request(FUNC_INSERT, 4, 32'd12345);
        send_request(FUNC_INSERT, 6, 32'h2222_2222);
        send_request(FUNC_READ,   0, '0);
        send_request(FUNC_READ,   4, '0);
        send_request(FUNC_READ,   5, '0);
        send_request(FUNC_WRITE,  2, 32'h5555_5555);
        send_request(FUNC_READ,   2, '0);
        send_request(FUNC_REMOVE, 1, '0);
        send_request(FUNC_REMOVE, 3, '0);
        send_request(FUNC_REMOVE, 0, '0);
        send_request(FUNC_REMOVE, 2, '0);
        send_request(FUNC_SPARE_FIRST, 0, 32'haaaa_aaaa);
        send_request(FUNC_SPARE_LAST, POS_MAX, '1);
        send_request(FUNC_INSERT, POS_MAX, '1);
        send_request(FUNC_READ,   POS_MAX, '0);

        // Random batches; every fifth one fills the store and probes it when full.
        item_count = 0;
        batch      = 0;
        while (item_count < RANDOM_ITEMS) begin
            mode = (batch % 5 == 0) ? MODE_FILL : $urandom_range(MODE_GROW, MODE_MIX);
            calm = (batch >= 20 && batch < 26);
            if (mode == MODE_FILL) begin
                while (fill_mirror < DEPTH) begin
                    func = $urandom_range(0, 1) ? FUNC_APPEND : FUNC_INSERT;
                    send_request(func, $urandom_range(0, fill_mirror), pick_word());
                    item_count++;
                end
                send_request(FUNC_APPEND, 0, pick_word());
                send_request(FUNC_INSERT, $urandom_range(0, DEPTH), pick_word());
                send_request(FUNC_INSERT, $urandom_range(DEPTH + 1, POS_MAX), pick_word());
                send_request(FUNC_READ,   DEPTH - 1, pick_word());
                send_request(FUNC_WRITE,  DEPTH - 1, pick_word());
                send_request(FUNC_REMOVE, $urandom_range(0, DEPTH - 1), pick_word());
                item_count += 6;
            end else begin
                repeat (32) begin
                    func = pick_func(mode);
                    send_request(func, pick_position(func), pick_word());
                    if (func <= FUNC_WRITE) item_count++;
                end
            end
            batch++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Let the last results come out, then a margin for anything stray.
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("indexed_insert_delete_array: match");
        end else begin
            $display("indexed_insert_delete_array: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
design/iida_pkg.sv
design/iida_word_ram.sv
design/indexed_insert_delete_array.sv
sim/iida_checker.sv
sim/tb.sv
